/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the byte set sort and statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

/* hdl/bsss_pkg.sv */
// Package with the payload types and constants of the byte set sort and statistics block.
package bsss_pkg;

   // Default depth of the sample store.
   localparam int MAX_ITEMS_DEFAULT = 64;

   // Depth of the queue between the front and the back.
   localparam int Q_DEPTH  = 2;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

   // One input transaction.
   typedef struct packed {
      logic [7:0] sample;
      logic       is_last;
   } req_payload_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] sorted_value;
      logic [7:0] maximum;
      logic [7:0] minimum;
      logic [7:0] mean_floor;
      logic [7:0] median_value;
      logic [6:0] set_count;
      logic       overflowed;
      logic       last_out;
   } rsp_payload_type;

   // A classified sample as it travels from the front to the back.
   typedef struct packed {
      logic [7:0] sample;
      logic       keep;
      logic       is_last;
   } entry_type;

endpackage

/* hdl/bsss_front.sv */
// Front end: accepts input transactions and classifies each sample as kept or dropped.
module bsss_front #(
   parameter int MAX_ITEMS = bsss_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  bsss_pkg::req_payload_type req_data,
   output logic                      q_push,
   output bsss_pkg::entry_type       q_entry,
   input  logic                      q_full
);
   import bsss_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             keep;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign keep     = (cnt_ff != CNT_W'(MAX_ITEMS));

   assign q_entry.sample  = req_data.sample;
   assign q_entry.keep    = keep;
   assign q_entry.is_last = req_data.is_last;

   always_comb begin
      cnt_in = cnt_ff;
      if (q_push) begin
         if (req_data.is_last) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/bsss_queue.sv */
// Short queue of classified samples between the front end and the back end.
`include "assert_macros.svh"

module bsss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsss_pkg::entry_type entry_in,
   output logic                full,
   output logic                valid,
   input  logic                pop,
   output bsss_pkg::entry_type entry_out
);
   import bsss_pkg::*;

   entry_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff;
   logic [Q_PTR_W-1:0]  wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff;
   logic [Q_PTR_W-1:0]  rd_ptr_in;
   logic [Q_FILL_W-1:0] fill_ff;
   logic [Q_FILL_W-1:0] fill_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (fill_ff == Q_FILL_W'(Q_DEPTH));
   assign valid     = (fill_ff != '0);
   assign entry_out = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + Q_FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - Q_FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= Q_FILL_W'(Q_DEPTH))

endmodule

/* hdl/bsss_divider.sv */
// Restoring divider that produces one quotient bit per cycle for the floor mean.
`include "assert_macros.svh"

module bsss_divider #(
   parameter int DVD_W = 14,
   parameter int DSR_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);
   import bsss_pkg::*;

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff;
   logic              busy_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [DVD_W-1:0]  quo_ff;
   logic [DVD_W-1:0]  quo_in;
   logic [DSR_W-1:0]  rem_ff;
   logic [DSR_W-1:0]  rem_in;
   logic [DSR_W-1:0]  dsr_ff;
   logic [DSR_W-1:0]  dsr_in;
   logic [DSR_W:0]    trial;
   logic              fits;

   assign busy     = busy_ff;
   assign quotient = quo_ff;
   assign trial    = {rem_ff, quo_ff[DVD_W-1]};
   assign fits     = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DSR_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[DSR_W-1:0];
         end
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   `ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff)

endmodule

/* hdl/bsss_back.sv */
// Back end: sample store, running statistics, in-place descending sort and result emission.
`include "assert_macros.svh"

module bsss_back #(
   parameter int MAX_ITEMS = bsss_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  bsss_pkg::entry_type       q_entry,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output bsss_pkg::rsp_payload_type rsp_data
);
   import bsss_pkg::*;

   localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W = CNT_W + 8;

   typedef enum logic [7:0] {
      ST_LOAD    = 8'b0000_0001,
      ST_START   = 8'b0000_0010,
      ST_SORT    = 8'b0000_0100,
      ST_MED0    = 8'b0000_1000,
      ST_MED1    = 8'b0001_0000,
      ST_MED2    = 8'b0010_0000,
      ST_EMIT_RD = 8'b0100_0000,
      ST_EMIT_WR = 8'b1000_0000
   } back_state_type;

   back_state_type   state_ff;
   back_state_type   state_in;

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [7:0]       max_ff;
   logic [7:0]       max_in;
   logic [7:0]       min_ff;
   logic [7:0]       min_in;
   logic             drop_ff;
   logic             drop_in;

   logic [CNT_W-1:0] rd_ff;
   logic [CNT_W-1:0] rd_in;
   logic [CNT_W-1:0] pass_ff;
   logic [CNT_W-1:0] pass_in;
   logic             rv_ff;
   logic             rv_in;
   logic [AW-1:0]    ridx_ff;
   logic [AW-1:0]    ridx_in;
   logic [7:0]       carry_ff;
   logic [7:0]       carry_in;
   logic             tail_ff;
   logic             tail_in;
   logic [7:0]       med_a_ff;
   logic [7:0]       med_a_in;
   logic [7:0]       median_ff;
   logic [7:0]       median_in;

   logic             out_valid_ff;
   logic             out_valid_in;
   rsp_payload_type  out_ff;
   rsp_payload_type  out_in;
   logic             out_free;

   logic [7:0]       store [MAX_ITEMS];
   logic             we;
   logic [AW-1:0]    waddr;
   logic [7:0]       wdata;
   logic             re;
   logic [AW-1:0]    raddr;
   logic [7:0]       rdata_ff;

   logic [AW-1:0]    last_idx;
   logic [AW-1:0]    half_idx;
   logic [8:0]       mid_sum;

   logic             div_start;
   logic             div_busy;
   logic [SUM_W-1:0] div_quo;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign last_idx  = AW'(cnt_ff - CNT_W'(1));
   assign half_idx  = AW'(cnt_ff >> 1);
   assign mid_sum   = {1'b0, med_a_ff} + {1'b0, rdata_ff};

   bsss_divider #(
      .DVD_W (SUM_W),
      .DSR_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      drop_in      = drop_ff;
      rd_in        = rd_ff;
      pass_in      = pass_ff;
      rv_in        = 1'b0;
      ridx_in      = ridx_ff;
      carry_in     = carry_ff;
      tail_in      = tail_ff;
      med_a_in     = med_a_ff;
      median_in    = median_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      re           = 1'b0;
      raddr        = '0;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.keep) begin
                  we     = 1'b1;
                  waddr  = cnt_ff[AW-1:0];
                  wdata  = q_entry.sample;
                  cnt_in = cnt_ff + CNT_W'(1);
                  sum_in = sum_ff + SUM_W'(q_entry.sample);
                  if (q_entry.sample > max_ff) begin
                     max_in = q_entry.sample;
                  end
                  if (q_entry.sample < min_ff) begin
                     min_in = q_entry.sample;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (q_entry.is_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            div_start = 1'b1;
            rd_in     = '0;
            tail_in   = 1'b0;
            pass_in   = cnt_ff - CNT_W'(1);
            state_in  = (cnt_ff > CNT_W'(1)) ? ST_SORT : ST_MED0;
         end
         ST_SORT: begin
            // One bubble pass streams the store: the smaller value is carried along
            // and the larger one is written back one place behind the read pointer.
            if (!tail_ff && (rd_ff != cnt_ff)) begin
               re      = 1'b1;
               raddr   = rd_ff[AW-1:0];
               rv_in   = 1'b1;
               ridx_in = rd_ff[AW-1:0];
               rd_in   = rd_ff + CNT_W'(1);
            end
            if (rv_ff) begin
               if (ridx_ff == '0) begin
                  carry_in = rdata_ff;
               end else begin
                  we       = 1'b1;
                  waddr    = ridx_ff - AW'(1);
                  wdata    = (carry_ff >= rdata_ff) ? carry_ff : rdata_ff;
                  carry_in = (carry_ff >= rdata_ff) ? rdata_ff : carry_ff;
               end
               if (ridx_ff == last_idx) begin
                  tail_in = 1'b1;
               end
            end
            if (tail_ff) begin
               we      = 1'b1;
               waddr   = last_idx;
               wdata   = carry_ff;
               tail_in = 1'b0;
               rd_in   = '0;
               if (pass_ff == CNT_W'(1)) begin
                  state_in = ST_MED0;
               end else begin
                  pass_in = pass_ff - CNT_W'(1);
               end
            end
         end
         ST_MED0: begin
            re       = 1'b1;
            raddr    = half_idx;
            state_in = ST_MED1;
         end
         ST_MED1: begin
            med_a_in = rdata_ff;
            re       = 1'b1;
            raddr    = half_idx - AW'(1);
            state_in = ST_MED2;
         end
         ST_MED2: begin
            median_in = cnt_ff[0] ? med_a_ff : mid_sum[8:1];
            if (!div_busy) begin
               rd_in    = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            re       = 1'b1;
            raddr    = rd_ff[AW-1:0];
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               out_valid_in        = 1'b1;
               out_in.sorted_value = rdata_ff;
               out_in.maximum      = max_ff;
               out_in.minimum      = min_ff;
               out_in.mean_floor   = div_quo[7:0];
               out_in.median_value = median_ff;
               out_in.set_count    = 7'(cnt_ff);
               out_in.overflowed   = drop_ff;
               out_in.last_out     = (rd_ff[AW-1:0] == last_idx);
               if (rd_ff[AW-1:0] == last_idx) begin
                  cnt_in   = '0;
                  sum_in   = '0;
                  max_in   = 8'd0;
                  min_in   = 8'd255;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  rd_in    = rd_ff + CNT_W'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         max_ff       <= 8'd0;
         min_ff       <= 8'd255;
         drop_ff      <= 1'b0;
         rv_ff        <= 1'b0;
         tail_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         drop_ff      <= drop_in;
         rv_ff        <= rv_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff     <= rd_in;
      pass_ff   <= pass_in;
      ridx_ff   <= ridx_in;
      carry_ff  <= carry_in;
      med_a_ff  <= med_a_in;
      median_ff <= median_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store[raddr];
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= CNT_W'(MAX_ITEMS))
   `ASSERT_IMPLY(a_emit_after_div, clock, reset, state_ff == ST_EMIT_RD, !div_busy)
   `ASSERT_IMPLY(a_sort_wr_range, clock, reset, (state_ff == ST_SORT) && we, CNT_W'(waddr) < cnt_ff)

endmodule

/* hdl/byte_set_sort_and_statistics_top.sv */
// Top level of the byte set sort and statistics block.

// This block collects a data set of unsigned bytes, one sample per input transaction, with
// the final sample marked by is_last. Up to MAX_ITEMS samples are kept; later samples of the
// same set are dropped and reported through the overflowed flag. After the last sample the
// set is sorted into descending order and one result transaction is delivered per kept
// sample, largest first, each carrying the maximum, minimum, floor mean, median and count of
// the set, with last_out marking the final one. Samples are taken one per cycle, while the
// queue has room, into a two-entry queue and written into the sample store one per cycle
// while the back end is loading. A set of n samples then passes through a start state and
// n - 1 bubble passes, each streaming the set through the store's single read port and
// single write port, and then the median fetch. The floor mean comes from a bit-serial
// divider that runs alongside the sort and needs one cycle per bit of the running sum, so
// for small sets the divider rather than the sort decides when results can start. Results
// leave paced by the registered read of the store. While a set is being sorted
// the queue keeps accepting up to two samples of the next set. A finished result waits in
// the output register, and the back end produces the next one only once that result has
// been taken, so a stalled receiver stalls the sort output and, once the queue is full, the
// input as well. The store needs no clearing after reset.
module byte_set_sort_and_statistics_top #(
   parameter int MAX_ITEMS = bsss_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  bsss_pkg::req_payload_type req_data,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output bsss_pkg::rsp_payload_type rsp_data
);
   import bsss_pkg::*;

   // Classified samples on their way from the front end into the queue.
   logic      fq_push;
   logic      fq_full;
   entry_type fq_entry;

   // Classified samples on their way from the queue into the back end.
   logic      qb_valid;
   logic      qb_pop;
   entry_type qb_entry;

   // The front end decides, transaction by transaction, whether a sample still fits in the
   // store, so the back end only has to act on the flags it receives.
   bsss_front #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_entry  (fq_entry),
      .q_full   (fq_full)
   );

   // The queue lets the producer keep pushing while the back end is busy sorting.
   bsss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .entry_in  (fq_entry),
      .full      (fq_full),
      .valid     (qb_valid),
      .pop       (qb_pop),
      .entry_out (qb_entry)
   );

   // The back end owns the store, the statistics, the sort and the output register.
   bsss_back #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_pop     (qb_pop),
      .q_entry   (qb_entry),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
